FILE: rtl/core/gdd_pkg.sv
// Shared constants, types and calendar tables for the Gregorian day difference core.
package gdd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned NUM_W   = 23;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned ORDER_W = 2;

    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 32;

    localparam int unsigned MIN_YEAR = 1600;
    localparam int unsigned MAX_YEAR = 9999;

    // floor(y / 100) == (y * DIV100_MULT) >> DIV100_SHIFT for all 14-bit y
    localparam int unsigned DIV100_MULT  = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned DIV100_PROD_W = YEAR_W + 13;
    localparam int unsigned Q100_W = 8;

    // floor(t / 7) == (t * DIV7_MULT) >> DIV7_SHIFT for all 23-bit t
    localparam int unsigned DIV7_MULT  = 9586981;
    localparam int unsigned DIV7_SHIFT = 26;
    localparam int unsigned DIV7_PROD_W = NUM_W + 24;
    localparam int unsigned Q7_W = DIV7_PROD_W - DIV7_SHIFT;

    // Day number of Monday 1 January 1900; offset keeps the weekday count positive
    localparam int unsigned BASE_DAY_NUM = 693901;
    localparam int unsigned WD_SHIFT     = BASE_DAY_NUM - 1 - 7 * 20000;

    typedef enum logic [ORDER_W-1:0] {
        ORDER_EQUAL   = 2'd0,
        ORDER_EARLIER = 2'd1,
        ORDER_LATER   = 2'd2
    } order_t;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
    } date_num_t;

    // Days before the first of the month in a March-based year
    function automatic logic [8:0] doy_base(input logic [MONTH_W-1:0] month);
        logic [8:0] base;
        case (month)
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/gdd_date_num.sv
// Three-stage pipeline that checks one date and maps it to its day number.
module gdd_date_num #(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gdd_pkg::DAY_W-1:0]     day,
    input  logic [gdd_pkg::MONTH_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]    year,
    output gdd_pkg::date_num_t            date_num
);

    localparam int unsigned PW = gdd_pkg::DIV100_PROD_W;
    localparam int unsigned QW = gdd_pkg::Q100_W;
    localparam int unsigned YW = gdd_pkg::YEAR_W;
    localparam int unsigned NW = gdd_pkg::NUM_W;

    // Stage 1: decode month, March-based year, reciprocal products
    logic [gdd_pkg::DAY_W-1:0]   day_reg;
    logic [gdd_pkg::MONTH_W-1:0] month_reg;
    logic [YW-1:0]               year_reg, year_next;
    logic [YW-1:0]               yp_reg, yp_next;
    logic [8:0]                  doy_reg, doy_next;
    logic [PW-1:0]               prod_y_reg, prod_y_next;
    logic [PW-1:0]               prod_yp_reg, prod_yp_next;

    always_comb
    begin
        year_next    = year;
        yp_next      = (month <= 4'd2) ? year - 14'd1 : year;
        doy_next     = gdd_pkg::doy_base(month) + 9'(day) - 9'd1;
        prod_y_next  = PW'(year) * PW'(gdd_pkg::DIV100_MULT);
        prod_yp_next = PW'(yp_next) * PW'(gdd_pkg::DIV100_MULT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            day_reg     <= day;
            month_reg   <= month;
            year_reg    <= year_next;
            yp_reg      <= yp_next;
            doy_reg     <= doy_next;
            prod_y_reg  <= prod_y_next;
            prod_yp_reg <= prod_yp_next;
        end
    end

    // Stage 2: leap year, validity, partial sums of the day number
    logic [QW-1:0]        q_y, q_yp;
    logic [YW-1:0]        rem_y;
    logic                 leap;
    logic [gdd_pkg::DAY_W-1:0] len;
    logic                 valid2_reg, valid2_next;
    logic [NW-1:0]        years_reg, years_next;
    logic signed [10:0]   frac_reg, frac_next;

    always_comb
    begin
        q_y   = prod_y_reg[gdd_pkg::DIV100_SHIFT +: QW];
        q_yp  = prod_yp_reg[gdd_pkg::DIV100_SHIFT +: QW];
        rem_y = year_reg - YW'(q_y) * YW'(100);
        leap  = (year_reg[1:0] == 2'b00) && ((rem_y != '0) || (q_y[1:0] == 2'b00));
        len   = gdd_pkg::month_length(month_reg, leap);
        valid2_next = (32'(year_reg) >= gdd_pkg::MIN_YEAR)
                   && (32'(year_reg) <= MAX_YEAR)
                   && (month_reg inside {[4'd1:4'd12]})
                   && (day_reg != '0) && (day_reg <= len);
        years_next = NW'(yp_reg) * NW'(365) + NW'(yp_reg[YW-1:2]);
        frac_next  = $signed({2'b00, doy_reg}) + $signed({5'b0, q_yp[QW-1:2]})
                   - $signed({3'b000, q_yp});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid2_reg <= valid2_next;
            years_reg  <= years_next;
            frac_reg   <= frac_next;
        end
    end

    // Stage 3: final add
    logic          valid3_reg;
    logic [NW-1:0] num3_reg, num3_next;

    assign num3_next = years_reg + NW'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid3_reg <= valid2_reg;
            num3_reg   <= num3_next;
        end
    end

    assign date_num.valid = valid3_reg;
    assign date_num.num   = num3_reg;

endmodule

FILE: rtl/core/gregorian_day_difference_core.sv
// Top level: signed day difference, weekday, order and validity of two Gregorian dates.
//
// Takes one pair of dates per cycle and returns one result word per pair,
// registered at every stage: three stages map each date to a closed-form day
// number, one subtracts, one multiplies by a reciprocal of seven for the
// weekday, and the last is the output register. The whole pipeline advances
// together whenever the output register is empty or being read, so with the
// output side ready the rate is one word per cycle; while the output stalls,
// every stage holds and s_axis_tready is low. Dates are valid for years 1600
// through MAX_YEAR (9999 by default); if either date is invalid, day difference
// and weekday read 0.
module gregorian_day_difference_core #(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  logic [gdd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // day_difference, second_weekday, order_code, first_valid, second_valid
    output logic [gdd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int unsigned NW    = gdd_pkg::NUM_W;
    localparam int unsigned DW    = gdd_pkg::DAY_W;
    localparam int unsigned MW    = gdd_pkg::MONTH_W;
    localparam int unsigned YW    = gdd_pkg::YEAR_W;
    localparam int unsigned PW    = gdd_pkg::DIV7_PROD_W;
    localparam int unsigned STAGES = 5;

    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack the input word
    logic [DW-1:0] d1, d2;
    logic [MW-1:0] m1, m2;
    logic [YW-1:0] y1, y2;

    assign d1 = s_axis_tdata[0 +: DW];
    assign m1 = s_axis_tdata[DW +: MW];
    assign y1 = s_axis_tdata[DW+MW +: YW];
    assign d2 = s_axis_tdata[DW+MW+YW +: DW];
    assign m2 = s_axis_tdata[2*DW+MW+YW +: MW];
    assign y2 = s_axis_tdata[2*DW+2*MW+YW +: YW];

    // Valid bits travel with the data
    logic [STAGES-1:0] vld_reg, vld_next;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stages 1-3: day numbers
    gdd_pkg::date_num_t num1, num2;

    gdd_date_num #(
        .MAX_YEAR (MAX_YEAR)
    ) u_first (
        .clk      (clk),
        .en       (adv),
        .day      (d1),
        .month    (m1),
        .year     (y1),
        .date_num (num1)
    );

    gdd_date_num #(
        .MAX_YEAR (MAX_YEAR)
    ) u_second (
        .clk      (clk),
        .en       (adv),
        .day      (d2),
        .month    (m2),
        .year     (y2),
        .date_num (num2)
    );

    // Raw field order, held alongside the day number stages
    gdd_pkg::order_t order_next, ord1_reg, ord2_reg, ord3_reg;

    always_comb
    begin
        if ({y1, m1, d1} == {y2, m2, d2})
        begin
            order_next = gdd_pkg::ORDER_EQUAL;
        end
        else if ({y1, m1, d1} < {y2, m2, d2})
        begin
            order_next = gdd_pkg::ORDER_EARLIER;
        end
        else
        begin
            order_next = gdd_pkg::ORDER_LATER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ord1_reg <= order_next;
            ord2_reg <= ord1_reg;
            ord3_reg <= ord2_reg;
        end
    end

    // Stage 4: difference and shifted weekday count
    logic [NW-1:0]   diff4_reg, diff4_next;
    logic [NW-1:0]   cnt4_reg, cnt4_next;
    logic            fv4_reg, sv4_reg;
    gdd_pkg::order_t ord4_reg;

    assign diff4_next = num2.num - num1.num;
    assign cnt4_next  = num2.num - NW'(gdd_pkg::WD_SHIFT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff4_reg <= diff4_next;
            cnt4_reg  <= cnt4_next;
            fv4_reg   <= num1.valid;
            sv4_reg   <= num2.valid;
            ord4_reg  <= ord3_reg;
        end
    end

    // Stage 5: reciprocal product for the mod-7 weekday
    logic [PW-1:0]   prod5_reg, prod5_next;
    logic [NW-1:0]   diff5_reg;
    logic [2:0]      cnt5_reg;
    logic            fv5_reg, sv5_reg;
    gdd_pkg::order_t ord5_reg;

    assign prod5_next = PW'(cnt4_reg) * PW'(gdd_pkg::DIV7_MULT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod5_reg <= prod5_next;
            diff5_reg <= diff4_reg;
            cnt5_reg  <= cnt4_reg[2:0];
            fv5_reg   <= fv4_reg;
            sv5_reg   <= sv4_reg;
            ord5_reg  <= ord4_reg;
        end
    end

    // Output register
    logic [gdd_pkg::Q7_W-1:0]  q7;
    logic [gdd_pkg::WD_W-1:0]  wd;
    logic                      both_ok;
    logic [NW-1:0]             diff_out_reg, diff_out_next;
    logic [gdd_pkg::WD_W-1:0]  wd_out_reg, wd_out_next;
    gdd_pkg::order_t           ord_out_reg;
    logic                      fv_out_reg, sv_out_reg;
    logic                      out_vld_reg, out_vld_next;

    always_comb
    begin
        q7      = prod5_reg[gdd_pkg::DIV7_SHIFT +: gdd_pkg::Q7_W];
        // remainder is below 7, so the low three bits suffice
        wd      = cnt5_reg - 3'(q7[2:0] * 3'd7);
        both_ok = fv5_reg && sv5_reg;
        diff_out_next = both_ok ? diff5_reg : '0;
        wd_out_next   = both_ok ? wd : '0;
        out_vld_next  = vld_reg[STAGES-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_out_reg <= diff_out_next;
            wd_out_reg   <= wd_out_next;
            ord_out_reg  <= ord5_reg;
            fv_out_reg   <= fv5_reg;
            sv_out_reg   <= sv5_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, sv_out_reg, fv_out_reg, ord_out_reg,
                            wd_out_reg, diff_out_reg};

endmodule

FILE: dv/gregorian_day_difference_core_tb.sv
// Testbench for the Gregorian day difference core: scoreboard class with its own date predictor.
module gregorian_day_difference_core_tb;

    localparam int unsigned DAY_W      = gdd_pkg::DAY_W;
    localparam int unsigned MONTH_W    = gdd_pkg::MONTH_W;
    localparam int unsigned YEAR_W     = gdd_pkg::YEAR_W;
    localparam int unsigned NUM_W      = gdd_pkg::NUM_W;
    localparam int unsigned WD_W       = gdd_pkg::WD_W;
    localparam int unsigned IN_DATA_W  = gdd_pkg::IN_DATA_W;
    localparam int unsigned OUT_DATA_W = gdd_pkg::OUT_DATA_W;
    localparam int unsigned MIN_YEAR   = gdd_pkg::MIN_YEAR;
    localparam int unsigned MAX_YEAR   = gdd_pkg::MAX_YEAR;

    typedef struct {
        logic [NUM_W-1:0] diff;
        logic [WD_W-1:0]  weekday;
        gdd_pkg::order_t  order_code;
        logic             first_valid;
        logic             second_valid;
    } date_result_t;

    class day_diff_scoreboard;
        date_result_t expected_q[$];
        int           fails;
        longint       epoch_num;

        static function bit leap_yr(int y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int days_in_month(int m, int y);
            int len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = leap_yr(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        static function bit check_date(int d, int m, int y);
            if (y < MIN_YEAR || y > MAX_YEAR || m < 1 || m > 12)
                return 1'b0;
            return d >= 1 && d <= days_in_month(m, y);
        endfunction

        // March-based year so the leap day falls at the end of the counted year
        static function longint day_number(int d, int m, int y);
            longint yp;
            longint mp;
            longint doy;
            yp = (m <= 2) ? y - 1 : y;
            mp = (m + 9) % 12;
            doy = (153 * mp + 2) / 5 + d - 1;
            return 365 * yp + yp / 4 - yp / 100 + yp / 400 + doy;
        endfunction

        function new();
            fails = 0;
            epoch_num = day_number(1, 1, 1900);
        endfunction

        function void note_pair(logic [IN_DATA_W-1:0] word);
            date_result_t r;
            int d1, m1, y1, d2, m2, y2;
            longint n1, n2, wd;
            d1 = int'(word[4:0]);
            m1 = int'(word[8:5]);
            y1 = int'(word[22:9]);
            d2 = int'(word[27:23]);
            m2 = int'(word[31:28]);
            y2 = int'(word[45:32]);
            r.first_valid  = check_date(d1, m1, y1);
            r.second_valid = check_date(d2, m2, y2);
            // compare raw fields, valid or not
            if (y1 != y2)
                r.order_code = (y1 < y2) ? gdd_pkg::ORDER_EARLIER : gdd_pkg::ORDER_LATER;
            else if (m1 != m2)
                r.order_code = (m1 < m2) ? gdd_pkg::ORDER_EARLIER : gdd_pkg::ORDER_LATER;
            else if (d1 != d2)
                r.order_code = (d1 < d2) ? gdd_pkg::ORDER_EARLIER : gdd_pkg::ORDER_LATER;
            else
                r.order_code = gdd_pkg::ORDER_EQUAL;
            r.diff = '0;
            r.weekday = '0;
            if (r.first_valid && r.second_valid)
            begin
                n1 = day_number(d1, m1, y1);
                n2 = day_number(d2, m2, y2);
                wd = (n2 - epoch_num + 1) % 7;
                if (wd < 0)
                    wd += 7;
                r.diff = NUM_W'(n2 - n1);
                r.weekday = WD_W'(wd);
            end
            expected_q.push_back(r);
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] word);
            date_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result word 0x%08h arrived with no pair outstanding", word);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (word[22:0] !== e.diff)
            begin
                $error("day_difference: expected %0d, got %0d",
                       $signed(e.diff), $signed(word[22:0]));
                fails++;
            end
            if (word[25:23] !== e.weekday)
            begin
                $error("second_weekday: expected %0d, got %0d", e.weekday, word[25:23]);
                fails++;
            end
            if (word[27:26] !== e.order_code)
            begin
                $error("order_code: expected %0d, got %0d", e.order_code, word[27:26]);
                fails++;
            end
            if (word[28] !== e.first_valid)
            begin
                $error("first_valid: expected %0b, got %0b", e.first_valid, word[28]);
                fails++;
            end
            if (word[29] !== e.second_valid)
            begin
                $error("second_valid: expected %0b, got %0b", e.second_valid, word[29]);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    day_diff_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int holds_asked   = 0;

    gregorian_day_difference_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("gregorian_day_difference_core_tb: FAIL");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_pair(
        input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1, input logic [YEAR_W-1:0] y1,
        input logic [DAY_W-1:0] d2, input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        return {{(IN_DATA_W - 46){1'b0}}, y2, m2, d2, y1, m1, d1};
    endfunction

    // Mostly valid dates, some with one field out of range, some pure noise
    function automatic void rand_date(output logic [DAY_W-1:0] d,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [YEAR_W-1:0] y);
        int kind, yy, mm, dd;
        kind = $urandom_range(99);
        case ($urandom_range(9))
            0:       yy = $urandom_range(1600, 1700);
            1:       yy = $urandom_range(1850, 2100);
            2:       yy = $urandom_range(9900, 9999);
            default: yy = $urandom_range(1600, 9999);
        endcase
        mm = $urandom_range(1, 12);
        dd = $urandom_range(1, day_diff_scoreboard::days_in_month(mm, yy));
        if (kind >= 72 && kind < 88)
        begin
            case ($urandom_range(5))
                0: dd = 0;
                1:
                begin
                    case ($urandom_range(4))
                        0:       mm = 2;
                        1:       mm = 4;
                        2:       mm = 6;
                        3:       mm = 9;
                        default: mm = 11;
                    endcase
                    dd = $urandom_range(day_diff_scoreboard::days_in_month(mm, yy) + 1, 31);
                end
                2: mm = 0;
                3: mm = $urandom_range(13, 15);
                4: yy = $urandom_range(0, 1599);
                default: yy = $urandom_range(10000, 16383);
            endcase
        end
        else if (kind >= 88)
        begin
            dd = $urandom_range(31);
            mm = $urandom_range(15);
            yy = $urandom_range(16383);
        end
        d = DAY_W'(dd);
        m = MONTH_W'(mm);
        y = YEAR_W'(yy);
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_pair();
        logic [DAY_W-1:0]   d1, d2;
        logic [MONTH_W-1:0] m1, m2;
        logic [YEAR_W-1:0]  y1, y2;
        int rel;
        rand_date(d1, m1, y1);
        rand_date(d2, m2, y2);
        rel = $urandom_range(99);
        // pull the second date close to the first to exercise the order compare
        if (rel < 8)
        begin
            d2 = d1;
            m2 = m1;
            y2 = y1;
        end
        else if (rel < 16)
        begin
            m2 = m1;
            y2 = y1;
            d2 = DAY_W'($urandom_range(31));
        end
        else if (rel < 24)
        begin
            y2 = y1;
        end
        return pack_pair(d1, m1, y1, d2, m2, y2);
    endfunction

    task automatic send_word(input logic [IN_DATA_W-1:0] word);
        // idle for src_idle_pct percent of cycles
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_pair(word);
    endtask

    task automatic send_dates(input int d1, input int m1, input int y1,
                              input int d2, input int m2, input int y2);
        send_word(pack_pair(d1[DAY_W-1:0], m1[MONTH_W-1:0], y1[YEAR_W-1:0],
                            d2[DAY_W-1:0], m2[MONTH_W-1:0], y2[YEAR_W-1:0]));
    endtask

    // Result side: check every accepted word, then pick the next ready level
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial
    begin
        int waited;
        sb = new();
        src_idle_pct = 6;
        sink_idle_pct = 70;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_dates(1, 1, 1900, 1, 1, 1900);
        send_dates(1, 1, 1600, 31, 12, 9999);
        send_dates(31, 12, 9999, 1, 1, 1600);
        send_dates(29, 2, 2000, 29, 2, 1900);
        send_dates(28, 2, 2023, 1, 3, 2023);
        send_dates(28, 2, 2024, 1, 3, 2024);
        send_dates(29, 2, 2023, 29, 2, 2024);
        send_dates(29, 2, 1600, 1, 3, 1600);
        send_dates(31, 1, 2021, 31, 4, 2021);
        send_dates(0, 5, 2000, 15, 5, 2000);
        send_dates(1, 0, 2000, 1, 13, 2000);
        send_dates(31, 15, 16383, 31, 15, 16383);
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(31, 12, 1599, 1, 1, 1600);
        send_dates(31, 12, 9999, 1, 1, 10000);
        send_dates(31, 12, 1899, 1, 1, 1900);
        send_dates(1, 1, 1900, 31, 12, 1899);
        send_dates(15, 6, 2010, 15, 3, 2010);
        send_dates(20, 6, 2010, 10, 6, 2010);
        send_dates(10, 6, 2010, 20, 6, 2010);
        send_dates(1, 1, 2000, 1, 1, 1999);

        for (int i = 0; i < 370; i++)
            send_word(rand_pair());

        src_idle_pct = 70;
        sink_idle_pct = 6;
        for (int i = 0; i < 370; i++)
            send_word(rand_pair());

        // hold the result side off while words keep coming, so the pipe backs up
        src_idle_pct = 0;
        sink_idle_pct = 0;
        holds_asked <= holds_asked + 1;
        for (int i = 0; i < 370; i++)
            send_word(rand_pair());
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d result words never arrived", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0)
            $display("gregorian_day_difference_core_tb: PASS");
        else
            $display("gregorian_day_difference_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: gregorian_day_difference_core.f
rtl/core/gdd_pkg.sv
rtl/core/gdd_date_num.sv
rtl/core/gregorian_day_difference_core.sv
dv/gregorian_day_difference_core_tb.sv
